// File: hw/rtl/dtb_pkg.sv
`default_nettype none

package dtb_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int HALF  = DEPTH / 2;
  localparam int DW    = 32 + 64 + 64;

  localparam logic [4:0] MAX_SHIFT = 5'd31;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [31:0]     iteration;
    logic [63:0]     train_bits;
    logic [63:0]     test_bits;
    logic [AW-1:0]   index;
  } item_t;

endpackage

`default_nettype wire

// File: hw/rtl/dtb_front.sv
`default_nettype none

module dtb_front
  import dtb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [31:0]   in_iteration_number,
  input  wire logic [63:0]   in_train_error_bits,
  input  wire logic [63:0]   in_test_error_bits,
  input  wire logic [AW-1:0] in_read_index,
  output logic               q_valid,
  output item_t              q_item,
  input  wire logic          q_pop
);

  item_t      q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    item.op         = op_t'(in_opcode);
    item.iteration  = in_iteration_number;
    item.train_bits = in_train_error_bits;
    item.test_bits  = in_test_error_bits;
    item.index      = in_read_index;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dtb_back.sv
`default_nettype none

module dtb_back
  import dtb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire item_t         q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [AW-1:0]      out_point_count,
  output logic [4:0]         out_stride_shift,
  output logic               out_read_valid,
  output logic [31:0]        out_read_iteration,
  output logic [63:0]        out_read_train_bits,
  output logic [63:0]        out_read_test_bits
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RD    = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_TAIL  = 4'b1000
  } state_t;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [4:0]    stride_r, stride_nxt;
  logic [31:0]   sample_r, sample_nxt;
  logic [AW-2:0] sweep_k_r, sweep_k_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_cnt_r;
  logic [4:0]    out_stride_r;
  logic          out_rv_r;
  logic [DW-1:0] out_data_r;

  logic          take, load, rd_hit, keep, full;
  logic [31:0]   samp_inc, stride_mask;
  logic [CW-1:0] cnt_inc;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;
  logic          push_we;
  logic          ld_rv;
  logic [DW-1:0] ld_data;

  assign take        = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_ready);
  assign q_pop       = take;
  assign samp_inc    = sample_r + 32'd1;
  assign stride_mask = (32'd1 << stride_r) - 32'd1;
  assign keep        = (samp_inc & stride_mask) == 32'd0;
  assign cnt_inc     = cnt_r + {{(CW-1){1'b0}}, 1'b1};
  assign full        = (cnt_inc == CW'(DEPTH));
  assign rd_hit      = ({1'b0, q_item.index} < cnt_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    stride_nxt  = stride_r;
    sample_nxt  = sample_r;
    sweep_k_nxt = sweep_k_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    load        = 1'b0;
    ld_rv       = 1'b0;
    ld_data     = '0;
    push_we     = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = q_item.index;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          unique case (q_item.op)
            OP_PUSH: begin
              load       = 1'b1;
              sample_nxt = samp_inc;
              if (keep) begin
                push_we = 1'b1;
                cnt_nxt = cnt_inc;
                if (full) begin
                  cnt_nxt     = CW'(HALF);
                  stride_nxt  = (stride_r == MAX_SHIFT) ? stride_r : stride_r + 5'd1;
                  sweep_k_nxt = '0;
                  state_nxt   = ST_SWEEP;
                end
              end
            end
            OP_READ: begin
              if (rd_hit) begin
                mem_re    = 1'b1;
                state_nxt = ST_RD;
              end else begin
                load = 1'b1;
              end
            end
            OP_CLEAR: begin
              load       = 1'b1;
              cnt_nxt    = '0;
              stride_nxt = '0;
              sample_nxt = '0;
            end
            OP_NOP: begin
              load = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        load      = 1'b1;
        ld_rv     = 1'b1;
        ld_data   = rdata_r;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        mem_re      = 1'b1;
        mem_raddr   = {sweep_k_r, 1'b0};
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = {1'b0, sweep_k_r};
        sweep_k_nxt = sweep_k_r + {{(AW-2){1'b0}}, 1'b1};
        if (sweep_k_r == (AW-1)'(HALF - 1)) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = rdata_r;
    end else begin
      mem_we    = push_we;
      mem_waddr = cnt_r[AW-1:0];
      mem_wdata = {q_item.iteration, q_item.train_bits, q_item.test_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      stride_r    <= '0;
      sample_r    <= '0;
      sweep_k_r   <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stride_r    <= stride_nxt;
      sample_r    <= sample_nxt;
      sweep_k_r   <= sweep_k_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    if (load) begin
      out_cnt_r    <= cnt_nxt[AW-1:0];
      out_stride_r <= stride_nxt;
      out_rv_r     <= ld_rv;
      out_data_r   <= ld_data;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_point_count     = out_cnt_r;
  assign out_stride_shift    = out_stride_r;
  assign out_read_valid      = out_rv_r;
  assign out_read_iteration  = out_data_r[DW-1 -: 32];
  assign out_read_train_bits = out_data_r[127:64];
  assign out_read_test_bits  = out_data_r[63:0];

`ifndef ASSERT_OFF
  a_cnt_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CW'(DEPTH))
    else $error("stored count reached depth");

  a_sweep_half: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP || state_r == ST_TAIL) |-> cnt_r == CW'(HALF))
    else $error("count not halved during compaction");

  a_sweep_low_half: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> {1'b0, wr_addr_r} < CW'(HALF))
    else $error("compaction write beyond lower half");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |=> (out_valid_r && out_rv_r))
    else $error("read data not presented");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/decimating_trace_buffer.sv
// A push, clear or no-op beat passes the front queue, then the registered outputs; a read hit
// also passes the registered trace memory port. Throughput: one push per cycle while out_ready
// holds and no sweep runs; a read hit delays the next item. A push that fills the trace starts a
// compaction sweep (ST_SWEEP, ST_TAIL); input beats queue in the 2-entry front queue meanwhile.
// Reset: synchronous, active low; empties the queue, zeroes count, stride and sample counter.
// Trace memory contents are not cleared.
`default_nettype none

module decimating_trace_buffer
  import dtb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [31:0]   in_iteration_number,
  input  wire logic [63:0]   in_train_error_bits,
  input  wire logic [63:0]   in_test_error_bits,
  input  wire logic [AW-1:0] in_read_index,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [AW-1:0]      out_point_count,
  output logic [4:0]         out_stride_shift,
  output logic               out_read_valid,
  output logic [31:0]        out_read_iteration,
  output logic [63:0]        out_read_train_bits,
  output logic [63:0]        out_read_test_bits
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  dtb_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_iteration_number (in_iteration_number),
    .in_train_error_bits (in_train_error_bits),
    .in_test_error_bits  (in_test_error_bits),
    .in_read_index       (in_read_index),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop)
  );

  dtb_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_point_count     (out_point_count),
    .out_stride_shift    (out_stride_shift),
    .out_read_valid      (out_read_valid),
    .out_read_iteration  (out_read_iteration),
    .out_read_train_bits (out_read_train_bits),
    .out_read_test_bits  (out_read_test_bits)
  );

endmodule

`default_nettype wire
